FILE: hw/rtl/slbm_pkg.sv
// Package for the serial-load bank mapper: word structs, action and mirroring codes,
// register window and configuration index codes. No dependencies.
`default_nettype none

package slbm_pkg;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_NOT_MAPPER = 3'd1,
    ACT_MIRROR     = 3'd2,
    ACT_CHR8K      = 3'd3,
    ACT_CHR4K      = 3'd4,
    ACT_PRG32K     = 3'd5,
    ACT_PRG16K     = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    MIRROR_SINGLE     = 2'd0,
    MIRROR_VERTICAL   = 2'd1,
    MIRROR_HORIZONTAL = 2'd2
  } mirror_t;

  // internal register picked by address bits 14-13
  typedef enum logic [1:0] {
    WIN_CONTROL = 2'd0,
    WIN_CHR0    = 2'd1,
    WIN_CHR1    = 2'd2,
    WIN_PRG     = 2'd3
  } window_t;

  localparam int CfgIndexWidth = 8;
  localparam logic [CfgIndexWidth-1:0] CFG_PRG_BANK_COUNT = 8'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_CHR_BANK_COUNT = 8'd1;

  localparam logic [7:0]  PRG_BANK_COUNT_RESET = 8'd2;
  localparam logic [7:0]  CHR_BANK_COUNT_RESET = 8'd0;

  localparam logic [2:0]  SHIFT_LAST  = 3'd4;
  localparam logic [15:0] TARGET_CHR_LO = 16'h0000;
  localparam logic [15:0] TARGET_CHR_HI = 16'h1000;
  localparam logic [15:0] TARGET_PRG_LO = 16'h8000;
  localparam logic [15:0] TARGET_PRG_HI = 16'hC000;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  bank;
    logic [15:0] target;
    mirror_t     mirror_mode;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/serial_load_bank_mapper_unit.sv
// Serial-load bank mapper, top level. One CPU write word in, one action word out.
// Depends on slbm_pkg.
`default_nettype none

// Each accepted CPU write produces exactly one result word, in the cycle after it is
// taken; a new write can be taken every cycle, the only limit being the single
// output register (req_stall is high while that register holds a word the consumer
// stalls). Writes below 0x8000 report "not mapper". Bit 7 of the data clears the
// five-bit serial buffer; otherwise bit 0 is shifted in LSB first and the fifth bit
// commits the value to the register chosen by address bits 14-13. Users must write
// bank counts via the cfg port only while no write is in flight; the unit never checks.
module serial_load_bank_mapper_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire slbm_pkg::req_t                    req,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output slbm_pkg::rsp_t                         rsp,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [slbm_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [7:0]                        cfg_data
);

  logic [7:0] prg_bank_count;
  logic [7:0] chr_bank_count;

  logic [4:0] shift_buffer, shift_buffer_next;
  logic [2:0] shift_count, shift_count_next;
  logic [1:0] mirror_bits, mirror_bits_next;
  logic       prg_area_low, prg_area_low_next;
  logic       prg_size_16k, prg_size_16k_next;
  logic       chr_size_4k, chr_size_4k_next;
  logic       chr_select_lo, chr_select_lo_next;
  logic       chr_select_hi, chr_select_hi_next;

  slbm_pkg::rsp_t    rsp_next;
  slbm_pkg::window_t win;
  logic              accept;
  logic [4:0]        value;
  logic [7:0]        chr_half;
  logic [7:0]        chr_bank;
  logic [7:0]        prg_base;

  assign cfg_ready = 1'b1;
  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  assign win   = slbm_pkg::window_t'(req.address[14:13]);
  assign value = {req.data[0], shift_buffer[3:0]};

  // chr bank: low 4 bits, plus half the chr count when the select bit is set
  assign chr_half = {1'b0, chr_bank_count[7:1]};
  assign chr_bank = {4'd0, value[3:0]} + (value[4] ? chr_half : 8'd0);

  always_comb begin
    prg_base = 8'd0;
    if (prg_bank_count >= 8'd32) begin
      if (!chr_size_4k) begin
        if (chr_select_lo) prg_base = 8'd16;
      end else begin
        prg_base = {3'd0, chr_select_hi, chr_select_lo, 3'd0};
      end
    end else if (prg_bank_count >= 8'd16) begin
      if (chr_select_lo) prg_base = 8'd8;
    end
  end

  always_comb begin
    shift_buffer_next  = shift_buffer;
    shift_count_next   = shift_count;
    mirror_bits_next   = mirror_bits;
    prg_area_low_next  = prg_area_low;
    prg_size_16k_next  = prg_size_16k;
    chr_size_4k_next   = chr_size_4k;
    chr_select_lo_next = chr_select_lo;
    chr_select_hi_next = chr_select_hi;
    rsp_next             = '0;
    rsp_next.action      = slbm_pkg::ACT_NONE;
    rsp_next.mirror_mode = slbm_pkg::MIRROR_SINGLE;

    if (!req.address[15]) begin
      rsp_next.action = slbm_pkg::ACT_NOT_MAPPER;
    end else if (req.data[7]) begin
      shift_buffer_next = 5'd0;
      shift_count_next  = 3'd0;
      if (win == slbm_pkg::WIN_CONTROL) begin
        prg_area_low_next = 1'b1;
        prg_size_16k_next = 1'b1;
      end
    end else if (shift_count != slbm_pkg::SHIFT_LAST) begin
      shift_buffer_next[shift_count] = req.data[0];
      shift_count_next               = shift_count + 3'd1;
    end else begin
      // fifth bit: commit to the selected register
      shift_buffer_next = 5'd0;
      shift_count_next  = 3'd0;
      case (win)
        slbm_pkg::WIN_CONTROL: begin
          if (value[1:0] != mirror_bits) begin
            mirror_bits_next = value[1:0];
            rsp_next.action  = slbm_pkg::ACT_MIRROR;
            if (!value[1])     rsp_next.mirror_mode = slbm_pkg::MIRROR_SINGLE;
            else if (value[0]) rsp_next.mirror_mode = slbm_pkg::MIRROR_HORIZONTAL;
            else               rsp_next.mirror_mode = slbm_pkg::MIRROR_VERTICAL;
          end
          prg_area_low_next = value[2];
          prg_size_16k_next = value[3];
          chr_size_4k_next  = value[4];
        end
        slbm_pkg::WIN_CHR0: begin
          chr_select_lo_next = value[4];
          if (chr_bank_count != 8'd0) begin
            rsp_next.action = chr_size_4k ? slbm_pkg::ACT_CHR4K : slbm_pkg::ACT_CHR8K;
            rsp_next.bank   = chr_bank;
            rsp_next.target = slbm_pkg::TARGET_CHR_LO;
          end
        end
        slbm_pkg::WIN_CHR1: begin
          chr_select_hi_next = value[4];
          if (chr_bank_count != 8'd0 && chr_size_4k) begin
            rsp_next.action = slbm_pkg::ACT_CHR4K;
            rsp_next.bank   = chr_bank;
            rsp_next.target = slbm_pkg::TARGET_CHR_HI;
          end
        end
        default: begin
          if (!prg_size_16k) begin
            rsp_next.action = slbm_pkg::ACT_PRG32K;
            rsp_next.bank   = prg_base + {4'd0, value[3:0]};
            rsp_next.target = slbm_pkg::TARGET_PRG_LO;
          end else begin
            rsp_next.action = slbm_pkg::ACT_PRG16K;
            rsp_next.bank   = {prg_base[6:0], 1'b0} + {4'd0, value[3:0]};
            rsp_next.target = prg_area_low ? slbm_pkg::TARGET_PRG_LO
                                           : slbm_pkg::TARGET_PRG_HI;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= slbm_pkg::PRG_BANK_COUNT_RESET;
      chr_bank_count <= slbm_pkg::CHR_BANK_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == slbm_pkg::CFG_PRG_BANK_COUNT) prg_bank_count <= cfg_data;
      if (cfg_index == slbm_pkg::CFG_CHR_BANK_COUNT) chr_bank_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_buffer  <= 5'd0;
      shift_count   <= 3'd0;
      mirror_bits   <= 2'd0;
      prg_area_low  <= 1'b1;
      prg_size_16k  <= 1'b1;
      chr_size_4k   <= 1'b0;
      chr_select_lo <= 1'b0;
      chr_select_hi <= 1'b0;
    end else if (accept) begin
      shift_buffer  <= shift_buffer_next;
      shift_count   <= shift_count_next;
      mirror_bits   <= mirror_bits_next;
      prg_area_low  <= prg_area_low_next;
      prg_size_16k  <= prg_size_16k_next;
      chr_size_4k   <= chr_size_4k_next;
      chr_select_lo <= chr_select_lo_next;
      chr_select_hi <= chr_select_hi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // buffer position never runs past the fifth bit
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    shift_count <= slbm_pkg::SHIFT_LAST)
    else $error("shift count out of range");

  // every accepted word yields a result word on the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted write produced no result word");

  // writes below mapper space leave the serial buffer alone
  a_low_write_no_shift: assert property (@(posedge clk) disable iff (rst)
    accept && !req.address[15] |=> $stable(shift_count) && $stable(shift_buffer))
    else $error("low write disturbed the shift buffer");

  // only a fifth-bit commit of a mirroring change reports a mirror mode
  a_mirror_only_on_change: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.action != slbm_pkg::ACT_MIRROR |->
      rsp.mirror_mode == slbm_pkg::MIRROR_SINGLE)
    else $error("mirror mode reported without mirroring change");

endmodule

`default_nettype wire
